/* src/sact_pkg.sv */
// Shared types and constants for the set-associative cache tag model.
`default_nettype none

package sact_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int SET_IDX_W  = 6;
  localparam int CNT_W      = 32;
  localparam int LFSR_W     = 16;
  localparam int LFSR_CNT_W = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPL_POLICY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_POLICY = 3'd4;

  // Replacement policy codes
  localparam logic [1:0] POL_LRU    = 2'd0;
  localparam logic [1:0] POL_FIFO   = 2'd1;
  localparam logic [1:0] POL_RANDOM = 2'd2;

  localparam logic WPOL_WRITE_THROUGH = 1'b1;
  localparam logic MODE_WRITE         = 1'b1;

  localparam logic [3:0] OFFSET_MAX = 4'd12;
  localparam logic [2:0] INDEX_MAX  = 3'd6;

  // Row update outcome
  typedef struct packed {
    logic hit;
    logic write;
    logic advance;
  } sact_upd_t;

endpackage

`default_nettype wire

/* src/sact_store.sv */
// Tag and valid memories, one set row per entry, with a post-reset valid clear sweep.
`default_nettype none

module sact_store #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8,
  parameter int SET_W    = 6
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   rd_en,
  input  wire logic [SET_W-1:0]                       rd_addr,
  output logic      [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] rd_tags,
  output logic      [MAX_WAYS-1:0]                    rd_valid,
  input  wire logic                                   wr_en,
  input  wire logic [SET_W-1:0]                       wr_addr,
  input  wire logic [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] wr_tags,
  input  wire logic [MAX_WAYS-1:0]                    wr_valid,
  output logic                                        busy
);

  logic [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] tag_mem [MAX_SETS];
  logic [MAX_WAYS-1:0]                      valid_mem [MAX_SETS];

  logic             clearing;
  logic [SET_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == SET_W'(MAX_SETS - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= wr_tags;
    end
    if (rd_en) begin
      rd_tags <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_idx] <= '0;
    end else if (wr_en) begin
      valid_mem[wr_addr] <= wr_valid;
    end
    if (rd_en) begin
      rd_valid <= valid_mem[rd_addr];
    end
  end

  assign busy = clearing;

endmodule

`default_nettype wire

/* src/sact_lfsr.sv */
// Replacement LFSR with a bit-serial remainder against the ways in use.
`default_nettype none

module sact_lfsr #(
  parameter int WCNT_W = 4,
  parameter int REM_W  = 5
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [WCNT_W-1:0] ways,
  input  wire logic              advance,
  output logic      [REM_W-2:0]  victim,
  output logic                   ready
);

  logic [sact_pkg::LFSR_W-1:0]     lfsr;
  logic [sact_pkg::LFSR_W-1:0]     lfsr_next;
  logic [REM_W-1:0]                rem;
  logic [REM_W-1:0]                rem_sh;
  logic [REM_W-1:0]                rem_step;
  logic [sact_pkg::LFSR_CNT_W-1:0] cnt;
  logic                            running;
  logic                            stale;
  logic [WCNT_W-1:0]               ways_seen;
  logic                            start;

  // taps 16,14,13,11, shifting right
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[sact_pkg::LFSR_W-1:1]};

  assign rem_sh   = {rem[REM_W-2:0], lfsr[cnt]};
  assign rem_step = (rem_sh >= {1'b0, ways}) ? rem_sh - {1'b0, ways} : rem_sh;
  assign start    = !running && (stale || ways != ways_seen);

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr      <= sact_pkg::LFSR_SEED;
      running   <= 1'b0;
      stale     <= 1'b1;
      ways_seen <= '0;
    end else if (advance) begin
      lfsr  <= lfsr_next;
      stale <= 1'b1;
    end else if (start) begin
      running   <= 1'b1;
      stale     <= 1'b0;
      ways_seen <= ways;
      cnt       <= '1;
      rem       <= '0;
    end else if (running) begin
      rem <= rem_step;
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        running <= 1'b0;
      end
    end
  end

  assign victim = rem[REM_W-2:0];
  assign ready  = !running && !stale && ways == ways_seen;

endmodule

`default_nettype wire

/* src/sact_row_update.sv */
// Way lookup and replacement update for one set row.
`default_nettype none

module sact_row_update #(
  parameter int MAX_WAYS = 8,
  parameter int WAY_W    = 3,
  parameter int WCNT_W   = 4
) (
  input  wire logic [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] old_tags,
  input  wire logic [MAX_WAYS-1:0]                    old_valid,
  input  wire logic [sact_pkg::TAG_W-1:0]             tag_in,
  input  wire logic                                   mode,
  input  wire logic [WCNT_W-1:0]                      ways,
  input  wire logic [1:0]                             repl_policy,
  input  wire logic                                   write_policy,
  input  wire logic [WAY_W-1:0]                       victim,
  output logic      [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] new_tags,
  output logic      [MAX_WAYS-1:0]                    new_valid,
  output sact_pkg::sact_upd_t                         upd
);

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] empty;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    empty_way;
  logic [WAY_W-1:0]    last_way;
  logic [WAY_W-1:0]    top;
  logic                allocate;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = WCNT_W'(i) < ways;
      match[i]  = in_use[i] && old_valid[i] && old_tags[i] == tag_in;
      empty[i]  = in_use[i] && !old_valid[i];
    end
    hit_way   = '0;
    empty_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = WAY_W'(i);
      end
      if (empty[i]) begin
        empty_way = WAY_W'(i);
      end
    end
  end

  assign last_way = WAY_W'(ways - WCNT_W'(1));
  assign allocate = !(write_policy == sact_pkg::WPOL_WRITE_THROUGH &&
                      mode == sact_pkg::MODE_WRITE);
  assign top      = (|match) ? hit_way : last_way;

  always_comb begin
    new_tags    = old_tags;
    new_valid   = old_valid;
    upd.hit     = |match;
    upd.write   = 1'b0;
    upd.advance = 1'b0;
    if (repl_policy == sact_pkg::POL_LRU && (upd.hit || allocate)) begin
      // move-to-front: ways up to top shift by one, new tag at way 0
      upd.write = 1'b1;
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (j == 0) begin
          new_tags[j]  = tag_in;
          new_valid[j] = 1'b1;
        end else if (WAY_W'(j) <= top) begin
          new_tags[j]  = old_tags[j-1];
          new_valid[j] = old_valid[j-1];
        end
      end
    end else if (!upd.hit && allocate &&
                 (repl_policy == sact_pkg::POL_FIFO || repl_policy == sact_pkg::POL_RANDOM)) begin
      upd.write = 1'b1;
      if (|empty) begin
        new_tags[empty_way]  = tag_in;
        new_valid[empty_way] = 1'b1;
      end else if (repl_policy == sact_pkg::POL_FIFO) begin
        for (int i = 0; i < MAX_WAYS; i++) begin
          if (WAY_W'(i) < last_way) begin
            new_tags[i]  = old_tags[i+1 < MAX_WAYS ? i+1 : i];
            new_valid[i] = old_valid[i+1 < MAX_WAYS ? i+1 : i];
          end else if (WAY_W'(i) == last_way) begin
            new_tags[i]  = tag_in;
            new_valid[i] = 1'b1;
          end
        end
      end else begin
        new_tags[victim]  = tag_in;
        new_valid[victim] = 1'b1;
        upd.advance       = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* src/set_assoc_cache_tag_model_core.sv */
// Top level of the set-associative cache tag model: control, config, counters, result register.
`default_nettype none

// Channel  Handshake              Payload
// -------  ---------------------  -------------------------------------------------
// req      req_valid / req_ready  mode, address
// rsp      rsp_valid / rsp_ready  hit, set_index, tag, hit_count, miss_count,
//                                 access_count
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (cfg_ready is always high)
//
// An access first reads the set row from the tag/valid memories (registered read),
// then compares the ways in use and writes the updated row back.
// After reset the valid memory is cleared, one set per cycle, with req_ready low
// throughout. The random-victim remainder is recomputed bit-serially after reset,
// after each random replacement and after a change of the clamped way count: a load step,
// then one bit step per LFSR bit, with requests held. A stalled rsp holds the compare and write-back.

module set_assoc_cache_tag_model_core #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               req_valid,
  output logic                                    req_ready,
  input  wire logic                               mode,
  input  wire logic [sact_pkg::ADDR_W-1:0]        address,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_ready,
  output logic                                    hit,
  output logic      [sact_pkg::SET_IDX_W-1:0]     set_index,
  output logic      [sact_pkg::TAG_W-1:0]         tag,
  output logic      [sact_pkg::CNT_W-1:0]         hit_count,
  output logic      [sact_pkg::CNT_W-1:0]         miss_count,
  output logic      [sact_pkg::CNT_W-1:0]         access_count,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sact_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sact_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SET_W    = MAX_SETS > 1 ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W    = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
  localparam int REM_W    = WCNT_W + 1;
  localparam int SET_SPAN = 1 << sact_pkg::SET_IDX_W;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_t;

  state_t state;

  // configuration registers
  logic [3:0] offset_bits;
  logic [2:0] index_bits;
  logic [3:0] ways_in_use;
  logic [1:0] repl_sel;
  logic       write_policy;

  // effective (clamped) configuration
  logic [3:0]        ob;
  logic [2:0]        ib;
  logic [WCNT_W-1:0] ways;
  logic [4:0]        shamt;

  logic [sact_pkg::SET_IDX_W-1:0] setv;
  logic [sact_pkg::TAG_W-1:0]     tagv;
  logic [SET_W-1:0]               set_map [SET_SPAN];

  // captured request
  logic                           cur_mode;
  logic [sact_pkg::SET_IDX_W-1:0] cur_set;
  logic [sact_pkg::TAG_W-1:0]     cur_tag;
  logic [SET_W-1:0]               cur_row;

  logic [sact_pkg::CNT_W-1:0] hit_counter;
  logic [sact_pkg::CNT_W-1:0] miss_counter;
  logic [sact_pkg::CNT_W-1:0] access_counter;

  logic [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] rd_tags;
  logic [MAX_WAYS-1:0]                      rd_valid;
  logic [MAX_WAYS-1:0][sact_pkg::TAG_W-1:0] new_tags;
  logic [MAX_WAYS-1:0]                      new_valid;
  sact_pkg::sact_upd_t                      upd;

  logic             store_busy;
  logic             lfsr_ready;
  logic [REM_W-2:0] victim;
  logic             req_xfer;
  logic             done;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits  <= 4'd4;
      index_bits   <= 3'd6;
      ways_in_use  <= 4'd8;
      repl_sel     <= sact_pkg::POL_LRU;
      write_policy <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sact_pkg::CFG_OFFSET_BITS:  offset_bits  <= cfg_data;
        sact_pkg::CFG_INDEX_BITS:   index_bits   <= cfg_data[2:0];
        sact_pkg::CFG_WAYS_IN_USE:  ways_in_use  <= cfg_data;
        sact_pkg::CFG_REPL_POLICY:  repl_sel     <= cfg_data[1:0];
        sact_pkg::CFG_WRITE_POLICY: write_policy <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign ob    = (offset_bits > sact_pkg::OFFSET_MAX) ? sact_pkg::OFFSET_MAX : offset_bits;
  assign ib    = (index_bits > sact_pkg::INDEX_MAX) ? sact_pkg::INDEX_MAX : index_bits;
  assign shamt = 5'(ob) + 5'(ib);

  always_comb begin
    if (ways_in_use == 4'd0) begin
      ways = WCNT_W'(1);
    end else if (32'(ways_in_use) > MAX_WAYS) begin
      ways = WCNT_W'(MAX_WAYS);
    end else begin
      ways = WCNT_W'(ways_in_use);
    end
  end

  // address split
  assign setv = sact_pkg::SET_IDX_W'(address >> ob) &
                sact_pkg::SET_IDX_W'((7'd1 << ib) - 7'd1);
  assign tagv = address >> shamt;

  // set number folded onto the memory depth
  for (genvar g = 0; g < SET_SPAN; g++) begin : g_set_map
    assign set_map[g] = SET_W'(g % MAX_SETS);
  end

  assign req_ready = state == ST_IDLE && !store_busy && lfsr_ready;
  assign req_xfer  = req_valid && req_ready;
  assign done      = state == ST_LOOK && (!rsp_valid || rsp_ready);

  sact_store #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS),
    .SET_W    (SET_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (req_xfer),
    .rd_addr  (set_map[setv]),
    .rd_tags  (rd_tags),
    .rd_valid (rd_valid),
    .wr_en    (done && upd.write),
    .wr_addr  (cur_row),
    .wr_tags  (new_tags),
    .wr_valid (new_valid),
    .busy     (store_busy)
  );

  sact_row_update #(
    .MAX_WAYS (MAX_WAYS),
    .WAY_W    (WAY_W),
    .WCNT_W   (WCNT_W)
  ) u_update (
    .old_tags     (rd_tags),
    .old_valid    (rd_valid),
    .tag_in       (cur_tag),
    .mode         (cur_mode),
    .ways         (ways),
    .repl_policy  (repl_sel),
    .write_policy (write_policy),
    .victim       (WAY_W'(victim)),
    .new_tags     (new_tags),
    .new_valid    (new_valid),
    .upd          (upd)
  );

  sact_lfsr #(
    .WCNT_W (WCNT_W),
    .REM_W  (REM_W)
  ) u_lfsr (
    .clk     (clk),
    .rst     (rst),
    .ways    (ways),
    .advance (done && upd.advance),
    .victim  (victim),
    .ready   (lfsr_ready)
  );

  // control, counters and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rsp_valid      <= 1'b0;
      hit_counter    <= '0;
      miss_counter   <= '0;
      access_counter <= '0;
    end else begin
      // a new result in the same cycle takes the register over
      if (rsp_ready && !done) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            cur_mode <= mode;
            cur_set  <= setv;
            cur_tag  <= tagv;
            cur_row  <= set_map[setv];
            state    <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (done) begin
            access_counter <= access_counter + 1'b1;
            access_count   <= access_counter + 1'b1;
            if (upd.hit) begin
              hit_counter <= hit_counter + 1'b1;
              hit_count   <= hit_counter + 1'b1;
              miss_count  <= miss_counter;
            end else begin
              miss_counter <= miss_counter + 1'b1;
              miss_count   <= miss_counter + 1'b1;
              hit_count    <= hit_counter;
            end
            hit       <= upd.hit;
            set_index <= cur_set;
            tag       <= cur_tag;
            rsp_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
